// File: rtl/tsps_pkg.sv
// Shared constants, codes and control/status types of the step program sequencer.
package tsps_pkg;

   localparam int MAX_STEPS = 16;
   localparam int CHANNELS  = 4;
   localparam int LEVEL_W   = 8;
   localparam int DUR_W     = 32;
   localparam int CLK_W     = 32;
   localparam int TPS_W     = 16;
   localparam int CNT_W     = $clog2(MAX_STEPS + 1);
   localparam int IDX_W     = $clog2(MAX_STEPS);
   localparam int DUTY_W    = CHANNELS * LEVEL_W;
   localparam int ENTRY_W   = DUR_W + DUTY_W;
   localparam int ACT_W     = 3;
   localparam int ERR_W     = 2;

   localparam logic [TPS_W-1:0] TICKS_RESET = TPS_W'(1000);

   typedef enum logic [ACT_W-1:0] {
      ACT_MS_TICK  = 3'd0,
      ACT_PWM_TICK = 3'd1,
      ACT_TOGGLE   = 3'd2,
      ACT_APPEND   = 3'd3,
      ACT_DELETE   = 3'd4,
      ACT_ADJUST   = 3'd5
   } action_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_INDEX = 2'd2
   } error_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_WALK,
      ST_DECIDE,
      ST_FETCH0,
      ST_LOAD0,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_DISPATCH,
      OP_WALK,
      OP_DECIDE,
      OP_LOAD0,
      OP_SHIFT_WR,
      OP_SHIFT_END
   } dp_op_type;

   typedef struct packed {
      logic      latch;
      dp_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      action_type action;
      logic       second_run;
      logic       del_bad;
      logic       walk_done;
      logic       early;
      logic       walked_lt_total;
      logic       total_nz;
      logic       shift_more;
   } dp_status_type;

endpackage

// File: rtl/tsps_ctrl.sv
// Sequencing state machine: dispatch, duration walk, step load and table shift.
module tsps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  tsps_pkg::dp_status_type status,
   output tsps_pkg::ctrl_cmd_type  cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   tsps_pkg::state_type state_ff;
   tsps_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsps_pkg::ST_IDLE: begin
            if (start) begin
               state_in = tsps_pkg::ST_DISPATCH;
            end
         end
         tsps_pkg::ST_DISPATCH: begin
            priority if (status.action == tsps_pkg::ACT_MS_TICK && status.second_run) begin
               state_in = tsps_pkg::ST_WALK;
            end else if (status.action == tsps_pkg::ACT_DELETE && !status.del_bad) begin
               state_in = tsps_pkg::ST_SHIFT_RD;
            end else begin
               state_in = tsps_pkg::ST_RESP;
            end
         end
         tsps_pkg::ST_WALK: begin
            if (status.walk_done) begin
               state_in = tsps_pkg::ST_DECIDE;
            end
         end
         tsps_pkg::ST_DECIDE: begin
            if (!status.early && !status.walked_lt_total && status.total_nz) begin
               state_in = tsps_pkg::ST_FETCH0;
            end else begin
               state_in = tsps_pkg::ST_RESP;
            end
         end
         tsps_pkg::ST_FETCH0:   state_in = tsps_pkg::ST_LOAD0;
         tsps_pkg::ST_LOAD0:    state_in = tsps_pkg::ST_RESP;
         tsps_pkg::ST_SHIFT_RD: begin
            state_in = status.shift_more ? tsps_pkg::ST_SHIFT_WR : tsps_pkg::ST_RESP;
         end
         tsps_pkg::ST_SHIFT_WR: state_in = tsps_pkg::ST_SHIFT_RD;
         tsps_pkg::ST_RESP:     state_in = tsps_pkg::ST_IDLE;
         default:               state_in = tsps_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.latch = 1'b0;
      cmd.op    = tsps_pkg::OP_NONE;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         tsps_pkg::ST_IDLE: begin
            busy      = 1'b0;
            cmd.latch = start;
         end
         tsps_pkg::ST_DISPATCH: cmd.op = tsps_pkg::OP_DISPATCH;
         tsps_pkg::ST_WALK:     cmd.op = tsps_pkg::OP_WALK;
         tsps_pkg::ST_DECIDE:   cmd.op = tsps_pkg::OP_DECIDE;
         tsps_pkg::ST_FETCH0:   cmd.op = tsps_pkg::OP_NONE;
         tsps_pkg::ST_LOAD0:    cmd.op = tsps_pkg::OP_LOAD0;
         tsps_pkg::ST_SHIFT_RD: begin
            cmd.op = status.shift_more ? tsps_pkg::OP_NONE : tsps_pkg::OP_SHIFT_END;
         end
         tsps_pkg::ST_SHIFT_WR: cmd.op = tsps_pkg::OP_SHIFT_WR;
         tsps_pkg::ST_RESP:     rsp_valid = 1'b1;
         default:               cmd.op = tsps_pkg::OP_NONE;
      endcase
   end

endmodule

// File: rtl/tsps_datapath.sv
// Clock, divider, step table memory, duration accumulator and PWM registers.
module tsps_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  tsps_pkg::ctrl_cmd_type              cmd,
   output tsps_pkg::dp_status_type             status,
   input  logic [tsps_pkg::ACT_W-1:0]          req_action,
   input  logic [tsps_pkg::DUR_W-1:0]          req_step_duration,
   input  logic [tsps_pkg::LEVEL_W-1:0]        req_level_a,
   input  logic [tsps_pkg::LEVEL_W-1:0]        req_level_b,
   input  logic [tsps_pkg::LEVEL_W-1:0]        req_level_c,
   input  logic [tsps_pkg::LEVEL_W-1:0]        req_level_d,
   input  logic [7:0]                          req_step_index,
   input  logic signed [tsps_pkg::CLK_W-1:0]   req_clock_delta,
   input  logic                                csr_valid,
   input  logic [tsps_pkg::TPS_W-1:0]          csr_wdata,
   output logic [tsps_pkg::CHANNELS-1:0]       pin_levels,
   output logic                                is_running,
   output logic [tsps_pkg::CNT_W-1:0]          active_step,
   output logic [tsps_pkg::CNT_W-1:0]          steps_stored,
   output logic [tsps_pkg::ERR_W-1:0]          error_code,
   output logic [tsps_pkg::CLK_W-1:0]          clock_now
);

   localparam int CH  = tsps_pkg::CHANNELS;
   localparam int LW  = tsps_pkg::LEVEL_W;
   localparam int CW  = tsps_pkg::CNT_W;
   localparam int IW  = tsps_pkg::IDX_W;
   localparam int KW  = tsps_pkg::CLK_W;
   localparam int EW  = tsps_pkg::ENTRY_W;
   localparam int DW  = tsps_pkg::DUTY_W;

   logic [EW-1:0]               mem [tsps_pkg::MAX_STEPS];
   logic [EW-1:0]               rd_ff;
   logic                        we;
   logic [IW-1:0]               waddr;
   logic [EW-1:0]               wdata;

   logic [tsps_pkg::TPS_W-1:0]  tps_ff, tps_in;
   logic [KW-1:0]               clock_ff, clock_in;
   logic [tsps_pkg::TPS_W-1:0]  div_ff, div_in, div_dec;
   logic                        run_ff, run_in;
   logic [KW-1:0]               start_ff, start_in;
   logic [CW-1:0]               cur_ff, cur_in;
   logic [CW-1:0]               total_ff, total_in;
   logic [CH-1:0][LW-1:0]       active_ff, active_in;
   logic [LW-1:0]               phase_ff, phase_in;
   logic [CH-1:0]               pins_ff, pins_in;
   tsps_pkg::error_type         err_ff, err_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic                        rv_ff, rv_in;

   tsps_pkg::action_type        act_ff, act_in;
   logic [tsps_pkg::DUR_W-1:0]  dur_ff, dur_in;
   logic [DW-1:0]               lev_ff, lev_in;
   logic [7:0]                  sidx_ff, sidx_in;
   logic signed [KW-1:0]        delta_ff, delta_in;
   logic [CW-1:0]               walked_ff, walked_in;
   logic [KW-1:0]               acc_ff, acc_in;

   logic [DW-1:0]               rd_duties;
   logic [tsps_pkg::DUR_W-1:0]  rd_len;

   assign rd_duties = rd_ff[DW-1:0];
   assign rd_len    = rd_ff[EW-1:DW];
   assign div_dec   = (div_ff != '0) ? div_ff - 1'b1 : div_ff;

   assign status.action          = act_ff;
   assign status.second_run      = (div_dec == '0) && run_ff;
   assign status.del_bad         = (sidx_ff == '0) || (sidx_ff > 8'(total_ff));
   assign status.walk_done       = (idx_ff == walked_ff) && !rv_ff;
   assign status.early           = clock_ff < acc_ff;
   assign status.walked_lt_total = walked_ff < total_ff;
   assign status.total_nz        = total_ff != '0;
   assign status.shift_more      = idx_ff < total_ff;

   always_comb begin
      tps_in    = csr_valid ? csr_wdata : tps_ff;
      clock_in  = clock_ff;
      div_in    = div_ff;
      run_in    = run_ff;
      start_in  = start_ff;
      cur_in    = cur_ff;
      total_in  = total_ff;
      active_in = active_ff;
      phase_in  = phase_ff;
      pins_in   = pins_ff;
      err_in    = err_ff;
      idx_in    = idx_ff;
      rv_in     = rv_ff;
      act_in    = act_ff;
      dur_in    = dur_ff;
      lev_in    = lev_ff;
      sidx_in   = sidx_ff;
      delta_in  = delta_ff;
      walked_in = walked_ff;
      acc_in    = acc_ff;
      we        = 1'b0;
      waddr     = total_ff[IW-1:0];
      wdata     = {dur_ff, lev_ff};

      if (cmd.latch) begin
         act_in   = tsps_pkg::action_type'(req_action);
         dur_in   = req_step_duration;
         lev_in   = {req_level_d, req_level_c, req_level_b, req_level_a};
         sidx_in  = req_step_index;
         delta_in = req_clock_delta;
      end

      unique case (cmd.op)
         tsps_pkg::OP_DISPATCH: begin
            err_in = tsps_pkg::ERR_OK;
            unique case (act_ff)
               tsps_pkg::ACT_MS_TICK: begin
                  if (div_dec == '0) begin
                     div_in   = tps_ff;
                     clock_in = clock_ff + 1'b1;
                  end else begin
                     div_in = div_dec;
                  end
                  walked_in = (cur_ff < total_ff) ? cur_ff : total_ff;
                  idx_in    = '0;
                  rv_in     = 1'b0;
                  acc_in    = start_ff;
               end
               tsps_pkg::ACT_PWM_TICK: begin
                  if (run_ff) begin
                     phase_in = phase_ff + 1'b1;
                     for (int c = 0; c < CH; c++) begin
                        if (phase_in == '0 && active_ff[c] != '0) begin
                           pins_in[c] = 1'b1;
                        end
                        if (phase_in == active_ff[c]) begin
                           pins_in[c] = 1'b0;
                        end
                     end
                  end
               end
               tsps_pkg::ACT_TOGGLE: begin
                  run_in = !run_ff;
                  if (!run_ff) begin
                     start_in  = clock_ff;
                     cur_in    = '0;
                     active_in = '0;
                  end else begin
                     pins_in = '0;
                  end
               end
               tsps_pkg::ACT_APPEND: begin
                  if (total_ff >= CW'(tsps_pkg::MAX_STEPS)) begin
                     err_in = tsps_pkg::ERR_FULL;
                  end else begin
                     we       = 1'b1;
                     total_in = total_ff + 1'b1;
                  end
               end
               tsps_pkg::ACT_DELETE: begin
                  if (status.del_bad) begin
                     err_in = tsps_pkg::ERR_INDEX;
                  end else begin
                     idx_in = sidx_ff[CW-1:0];
                  end
               end
               tsps_pkg::ACT_ADJUST: begin
                  clock_in = clock_ff + $unsigned(delta_ff);
               end
               default: begin
                  err_in = tsps_pkg::ERR_OK;
               end
            endcase
         end
         tsps_pkg::OP_WALK: begin
            rv_in = idx_ff < walked_ff;
            if (idx_ff < walked_ff) begin
               idx_in = idx_ff + 1'b1;
            end
            if (rv_ff) begin
               acc_in = acc_ff + rd_len;
            end
         end
         tsps_pkg::OP_DECIDE: begin
            if (!status.early) begin
               if (status.walked_lt_total) begin
                  active_in = rd_duties;
                  cur_in    = walked_ff + 1'b1;
               end else begin
                  start_in = acc_ff;
                  if (status.total_nz) begin
                     idx_in = '0;
                  end else begin
                     active_in = '0;
                     cur_in    = '0;
                  end
               end
            end
         end
         tsps_pkg::OP_LOAD0: begin
            active_in = rd_duties;
            cur_in    = CW'(1);
         end
         tsps_pkg::OP_SHIFT_WR: begin
            we     = 1'b1;
            waddr  = IW'(idx_ff - 1'b1);
            wdata  = rd_ff;
            idx_in = idx_ff + 1'b1;
         end
         tsps_pkg::OP_SHIFT_END: begin
            total_in = total_ff - 1'b1;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff    <= tsps_pkg::TICKS_RESET;
         clock_ff  <= '0;
         div_ff    <= '0;
         run_ff    <= 1'b0;
         start_ff  <= '0;
         cur_ff    <= '0;
         total_ff  <= '0;
         active_ff <= '0;
         phase_ff  <= '0;
         pins_ff   <= '0;
         err_ff    <= tsps_pkg::ERR_OK;
         idx_ff    <= '0;
         rv_ff     <= 1'b0;
      end else begin
         tps_ff    <= tps_in;
         clock_ff  <= clock_in;
         div_ff    <= div_in;
         run_ff    <= run_in;
         start_ff  <= start_in;
         cur_ff    <= cur_in;
         total_ff  <= total_in;
         active_ff <= active_in;
         phase_ff  <= phase_in;
         pins_ff   <= pins_in;
         err_ff    <= err_in;
         idx_ff    <= idx_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff    <= act_in;
      dur_ff    <= dur_in;
      lev_ff    <= lev_in;
      sidx_ff   <= sidx_in;
      delta_ff  <= delta_in;
      walked_ff <= walked_in;
      acc_ff    <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[idx_ff[IW-1:0]];
   end

   assign pin_levels   = pins_ff;
   assign is_running   = run_ff;
   assign active_step  = cur_ff;
   assign steps_stored = total_ff;
   assign error_code   = err_ff;
   assign clock_now    = clock_ff;

endmodule

// File: rtl/timed_step_program_pwm_sequencer_core.sv
// Top level of the timed step program PWM sequencer.
// Each request passes dispatch; a ms tick that ends a second while running then walks the step
// durations (walked = min(active step, step count)) and reloads step one on a wrap; a delete
// moves each later entry down one place. The strobe follows, and busy drops as the strobe ends.
// Results cannot be stalled. Sync reset clears state, ticks_per_second 1000, table undefined.
module timed_step_program_pwm_sequencer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tsps_pkg::ACT_W-1:0]          req_action,
   input  logic [tsps_pkg::DUR_W-1:0]          req_step_duration,
   input  logic [tsps_pkg::LEVEL_W-1:0]        req_level_a,
   input  logic [tsps_pkg::LEVEL_W-1:0]        req_level_b,
   input  logic [tsps_pkg::LEVEL_W-1:0]        req_level_c,
   input  logic [tsps_pkg::LEVEL_W-1:0]        req_level_d,
   input  logic [7:0]                          req_step_index,
   input  logic signed [tsps_pkg::CLK_W-1:0]   req_clock_delta,
   output logic                                rsp_valid,
   output logic [tsps_pkg::CHANNELS-1:0]       rsp_pin_levels,
   output logic                                rsp_is_running,
   output logic [tsps_pkg::CNT_W-1:0]          rsp_active_step,
   output logic [tsps_pkg::CNT_W-1:0]          rsp_steps_stored,
   output logic [tsps_pkg::ERR_W-1:0]          rsp_error_code,
   output logic [tsps_pkg::CLK_W-1:0]          rsp_clock_now,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsps_pkg::TPS_W-1:0]          csr_wdata
);

   tsps_pkg::ctrl_cmd_type  cmd;
   tsps_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   tsps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   tsps_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_step_duration (req_step_duration),
      .req_level_a       (req_level_a),
      .req_level_b       (req_level_b),
      .req_level_c       (req_level_c),
      .req_level_d       (req_level_d),
      .req_step_index    (req_step_index),
      .req_clock_delta   (req_clock_delta),
      .csr_valid         (csr_valid & csr_ready),
      .csr_wdata         (csr_wdata),
      .pin_levels        (rsp_pin_levels),
      .is_running        (rsp_is_running),
      .active_step       (rsp_active_step),
      .steps_stored      (rsp_steps_stored),
      .error_code        (rsp_error_code),
      .clock_now         (rsp_clock_now)
   );

endmodule

// File: bench/testbench.sv
// Self-checking bench for the step program PWM sequencer: predicts and compares each beat.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tsps_pkg::*;

   localparam int RANDOM_BEATS   = 1850;
   localparam int CALM_TAIL      = 350;
   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;

   typedef struct packed {
      logic [ACT_W-1:0]    action;
      logic [DUR_W-1:0]    duration;
      logic [DUTY_W-1:0]   levels;
      logic [7:0]          index;
      logic [CLK_W-1:0]    delta;
   } beat_type;

   typedef struct packed {
      logic [CHANNELS-1:0] pins;
      logic                running;
      logic [CNT_W-1:0]    step;
      logic [CNT_W-1:0]    count;
      error_type           err;
      logic [CLK_W-1:0]    now;
   } status_type;

   typedef enum int {MIX_BUILD, MIX_RUN, MIX_PWM, MIX_SHRINK, MIX_NOISE} mix_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [ACT_W-1:0]          req_action;
   logic [DUR_W-1:0]          req_step_duration;
   logic [LEVEL_W-1:0]        req_level_a;
   logic [LEVEL_W-1:0]        req_level_b;
   logic [LEVEL_W-1:0]        req_level_c;
   logic [LEVEL_W-1:0]        req_level_d;
   logic [7:0]                req_step_index;
   logic signed [CLK_W-1:0]   req_clock_delta;
   logic                      rsp_valid;
   logic [CHANNELS-1:0]       rsp_pin_levels;
   logic                      rsp_is_running;
   logic [CNT_W-1:0]          rsp_active_step;
   logic [CNT_W-1:0]          rsp_steps_stored;
   logic [ERR_W-1:0]          rsp_error_code;
   logic [CLK_W-1:0]          rsp_clock_now;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [TPS_W-1:0]          csr_wdata;

   // sequencer state as predicted
   logic [TPS_W-1:0]  seq_tps;
   logic [TPS_W-1:0]  seq_divider;
   logic [CLK_W-1:0]  seq_clock;
   logic [CLK_W-1:0]  seq_origin;
   logic              seq_running;
   int unsigned       seq_step;
   int unsigned       seq_count;
   logic [DUR_W-1:0]  step_secs [MAX_STEPS];
   logic [DUTY_W-1:0] step_lvls [MAX_STEPS];
   logic [DUTY_W-1:0] live_lvls;
   logic [7:0]        pwm_ph;
   logic [CHANNELS-1:0] pin_bits;

   status_type status_due [$];
   status_type due_status;
   int      idle_pct;
   int      fail_count;
   int      results_checked;
   int      beat_tally [8];
   int      step_loads;
   int      full_errs;
   int      index_errs;
   int      tps_writes;
   int      quiet_cycles;

   timed_step_program_pwm_sequencer_core u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_step_duration (req_step_duration),
      .req_level_a       (req_level_a),
      .req_level_b       (req_level_b),
      .req_level_c       (req_level_c),
      .req_level_d       (req_level_d),
      .req_step_index    (req_step_index),
      .req_clock_delta   (req_clock_delta),
      .rsp_valid         (rsp_valid),
      .rsp_pin_levels    (rsp_pin_levels),
      .rsp_is_running    (rsp_is_running),
      .rsp_active_step   (rsp_active_step),
      .rsp_steps_stored  (rsp_steps_stored),
      .rsp_error_code    (rsp_error_code),
      .rsp_clock_now     (rsp_clock_now),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void advance_on_second();
      int unsigned      walked;
      logic [CLK_W-1:0] due;
      walked = (seq_step < seq_count) ? seq_step : seq_count;
      due = seq_origin;
      for (int i = 0; i < walked; i++)
         due = due + step_secs[i];
      if (seq_clock < due)
         return;
      step_loads++;
      if (walked < seq_count) begin
         live_lvls = step_lvls[walked];
         seq_step = walked + 1;
      end else begin
         seq_origin = due;
         if (seq_count > 0) begin
            live_lvls = step_lvls[0];
            seq_step = 1;
         end else begin
            live_lvls = '0;
            seq_step = 0;
         end
      end
   endfunction

   function automatic status_type apply_beat(input beat_type b);
      status_type s;
      error_type  err;
      logic [7:0] lvl;
      err = ERR_OK;
      case (b.action)
         ACT_MS_TICK: begin
            if (seq_divider != 0)
               seq_divider = seq_divider - 1'b1;
            if (seq_divider == 0) begin
               seq_divider = seq_tps;
               seq_clock = seq_clock + 1'b1;
               if (seq_running)
                  advance_on_second();
            end
         end
         ACT_PWM_TICK: begin
            if (seq_running) begin
               pwm_ph = pwm_ph + 1'b1;
               for (int c = 0; c < CHANNELS; c++) begin
                  lvl = live_lvls[LEVEL_W*c +: LEVEL_W];
                  if (pwm_ph == 0 && lvl != 0)
                     pin_bits[c] = 1'b1;
                  if (pwm_ph == lvl)
                     pin_bits[c] = 1'b0;
               end
            end
         end
         ACT_TOGGLE: begin
            seq_running = ~seq_running;
            if (seq_running) begin
               seq_origin = seq_clock;
               seq_step = 0;
               live_lvls = '0;
            end else begin
               pin_bits = '0;
            end
         end
         ACT_APPEND: begin
            if (seq_count >= MAX_STEPS) begin
               err = ERR_FULL;
            end else begin
               step_secs[seq_count] = b.duration;
               step_lvls[seq_count] = b.levels;
               seq_count++;
            end
         end
         ACT_DELETE: begin
            if (b.index == 0 || b.index > seq_count) begin
               err = ERR_INDEX;
            end else begin
               for (int i = b.index - 1; i + 1 < seq_count; i++) begin
                  step_secs[i] = step_secs[i+1];
                  step_lvls[i] = step_lvls[i+1];
               end
               seq_count--;
            end
         end
         ACT_ADJUST: seq_clock = seq_clock + b.delta;
         default: ;
      endcase
      if (err == ERR_FULL)
         full_errs++;
      if (err == ERR_INDEX)
         index_errs++;
      s.pins    = pin_bits;
      s.running = seq_running;
      s.step    = CNT_W'(seq_step);
      s.count   = CNT_W'(seq_count);
      s.err     = err;
      s.now     = seq_clock;
      return s;
   endfunction

   function automatic beat_type beat_of(input logic [ACT_W-1:0] act,
                                        input logic [DUR_W-1:0] dur,
                                        input logic [DUTY_W-1:0] lvls, input logic [7:0] idx,
                                        input logic [CLK_W-1:0] delta);
      beat_type b;
      b.action   = act;
      b.duration = dur;
      b.levels   = lvls;
      b.index    = idx;
      b.delta    = delta;
      return b;
   endfunction

   function automatic logic [7:0] pick_level();
      int unsigned r;
      r = $urandom_range(0, 3);
      if (r == 0)
         return 8'h00;
      if (r == 1)
         return 8'hFF;
      return 8'($urandom);
   endfunction

   function automatic beat_type make_beat(input mix_type kind);
      beat_type    b;
      int          w [6];
      int          roll;
      int          acc;
      int          pick;
      int unsigned r;
      b.action   = 3'($urandom);
      b.duration = $urandom;
      b.levels   = $urandom;
      b.index    = 8'($urandom);
      b.delta    = $urandom;
      if (kind == MIX_NOISE)
         return b;
      // weights in action-code order: ms, pwm, toggle, append, delete, adjust
      case (kind)
         MIX_BUILD:  w = '{25, 10, 5, 45, 5, 10};
         MIX_RUN:    w = '{55, 22, 3, 5, 5, 10};
         MIX_PWM:    w = '{8, 90, 1, 0, 0, 1};
         default:    w = '{25, 10, 5, 10, 45, 5};
      endcase
      roll = $urandom_range(0, 99);
      pick = 0;
      acc  = w[0];
      while (roll >= acc && pick < 5) begin
         pick++;
         acc += w[pick];
      end
      b.action = 3'(pick);
      r = $urandom_range(0, 9);
      if (r < 8)
         b.duration = $urandom_range(0, 3);
      else if (r == 8)
         b.duration = $urandom_range(4, 40);
      b.levels = {pick_level(), pick_level(), pick_level(), pick_level()};
      r = $urandom_range(0, 99);
      if (seq_count > 0 && r < 85)
         b.index = 8'($urandom_range(1, seq_count));
      else if (r < 90)
         b.index = 8'(seq_count + 1);
      r = $urandom_range(0, 9);
      if (r < 7)
         b.delta = $urandom_range(0, 20) - 10;
      else if (r < 9)
         b.delta = $urandom_range(0, 2000) - 1000;
      return b;
   endfunction

   task automatic flag_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      if (fail_count < 40)
         $display("%0t mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
                  $time, field, results_checked, got, want);
      fail_count++;
   endtask

   task automatic issue_beat(input beat_type b);
      req_action        <= b.action;
      req_step_duration <= b.duration;
      req_level_a       <= b.levels[7:0];
      req_level_b       <= b.levels[15:8];
      req_level_c       <= b.levels[23:16];
      req_level_d       <= b.levels[31:24];
      req_step_index    <= b.index;
      req_clock_delta   <= b.delta;
      start             <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      status_due.push_back(apply_beat(b));
      beat_tally[b.action]++;
   endtask

   task automatic hold_sender(input int unsigned n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic pace();
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
         hold_sender($urandom_range(1, 5));
   endtask

   task automatic settle();
      start <= 1'b0;
      while (status_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tps(input logic [TPS_W-1:0] value);
      settle();
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      seq_tps = value;
      tps_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_table();
      issue_beat(beat_of(ACT_DELETE, '0, '0, 8'd1, '0));
      issue_beat(beat_of(ACT_SPARE_A, '1, '1, 8'hFF, '1));
      issue_beat(beat_of(ACT_SPARE_B, '0, '0, 8'h00, '0));
      issue_beat(beat_of(ACT_PWM_TICK, '0, '0, 8'h00, '0));
      issue_beat(beat_of(ACT_MS_TICK, '0, '0, 8'h00, '0));
      issue_beat(beat_of(ACT_TOGGLE, '0, '0, 8'h00, '0));
      issue_beat(beat_of(ACT_MS_TICK, '0, '0, 8'h00, '0));
      issue_beat(beat_of(ACT_TOGGLE, '0, '0, 8'h00, '0));
      settle();
   endtask

   task automatic test_clock_adjust();
      issue_beat(beat_of(ACT_ADJUST, '0, '0, 8'h00, 32'h7FFF_FFFF));
      issue_beat(beat_of(ACT_ADJUST, '0, '0, 8'h00, 32'h8000_0000));
      issue_beat(beat_of(ACT_ADJUST, '0, '0, 8'h00, 32'hFFFF_FFFF));
      settle();
   endtask

   task automatic test_program_walk();
      issue_beat(beat_of(ACT_APPEND, 32'd0, {8'd128, 8'd1, 8'd0, 8'd255}, 8'h00, '0));
      issue_beat(beat_of(ACT_APPEND, 32'd2, {8'd1, 8'd128, 8'd255, 8'd0}, 8'h00, '0));
      issue_beat(beat_of(ACT_APPEND, 32'hFFFF_FFFF, {8'd255, 8'd255, 8'd1, 8'd1}, 8'h00, '0));
      issue_beat(beat_of(ACT_TOGGLE, '0, '0, 8'h00, '0));
      repeat (3) issue_beat(beat_of(ACT_MS_TICK, '0, '0, 8'h00, '0));
      repeat (2) issue_beat(beat_of(ACT_PWM_TICK, '0, '0, 8'h00, '0));
      settle();
   endtask

   task automatic test_delete_cases();
      issue_beat(beat_of(ACT_DELETE, '0, '0, 8'd0, '0));
      issue_beat(beat_of(ACT_DELETE, '0, '0, 8'd255, '0));
      // drop a step below the active one so the walk reaches the end of the table
      issue_beat(beat_of(ACT_DELETE, '0, '0, 8'd2, '0));
      issue_beat(beat_of(ACT_MS_TICK, '0, '0, 8'h00, '0));
      issue_beat(beat_of(ACT_TOGGLE, '0, '0, 8'h00, '0));
      settle();
   endtask

   task automatic test_random_mix();
      int      produced;
      int      seg;
      int      seg_len;
      mix_type kind;
      produced = 0;
      seg = 0;
      while (produced < RANDOM_BEATS) begin
         kind = (seg < 5) ? mix_type'(seg) : mix_type'($urandom_range(0, 4));
         seg_len = (kind == MIX_PWM) ? $urandom_range(150, 300) : $urandom_range(40, 100);
         idle_pct = $urandom_range(0, 2) * 25;
         if ((kind == MIX_RUN || kind == MIX_PWM) && !seq_running) begin
            pace();
            issue_beat(beat_of(ACT_TOGGLE, $urandom, $urandom, 8'($urandom), $urandom));
            produced++;
         end
         for (int n = 0; n < seg_len && produced < RANDOM_BEATS; n++) begin
            if (RANDOM_BEATS - produced <= CALM_TAIL)
               idle_pct = 0;
            pace();
            issue_beat(make_beat(kind));
            produced++;
         end
         if (RANDOM_BEATS - produced > CALM_TAIL && $urandom_range(0, 9) < 3)
            write_tps(TPS_W'($urandom_range(1, 5)));
         seg++;
      end
      settle();
   endtask

   task automatic test_slow_divider();
      idle_pct = 0;
      write_tps(TPS_W'(1));
      repeat (6) issue_beat(beat_of(ACT_MS_TICK, '0, '0, 8'h00, '0));
      write_tps(16'hFFFF);
      repeat (4) issue_beat(beat_of(ACT_MS_TICK, '0, '0, 8'h00, '0));
      issue_beat(beat_of(ACT_PWM_TICK, '0, '0, 8'h00, '0));
      issue_beat(beat_of(ACT_ADJUST, '0, '0, 8'h00, 32'd5));
      settle();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (status_due.size() == 0) begin
            flag_mismatch("orphan result", rsp_clock_now, '0);
         end else begin
            due_status = status_due.pop_front();
            if (rsp_pin_levels !== due_status.pins)
               flag_mismatch("pin_levels", rsp_pin_levels, due_status.pins);
            if (rsp_is_running !== due_status.running)
               flag_mismatch("is_running", rsp_is_running, due_status.running);
            if (rsp_active_step !== due_status.step)
               flag_mismatch("active_step", rsp_active_step, due_status.step);
            if (rsp_steps_stored !== due_status.count)
               flag_mismatch("steps_stored", rsp_steps_stored, due_status.count);
            if (rsp_error_code !== due_status.err)
               flag_mismatch("error_code", rsp_error_code, due_status.err);
            if (rsp_clock_now !== due_status.now)
               flag_mismatch("clock_now", rsp_clock_now, due_status.now);
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, status_due.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_action        <= ACT_MS_TICK;
      req_step_duration <= '0;
      req_level_a       <= '0;
      req_level_b       <= '0;
      req_level_c       <= '0;
      req_level_d       <= '0;
      req_step_index    <= '0;
      req_clock_delta   <= '0;
      csr_valid         <= 1'b0;
      csr_wdata         <= '0;
      seq_tps     = TICKS_RESET;
      seq_divider = '0;
      seq_clock   = '0;
      seq_origin  = '0;
      seq_running = 1'b0;
      seq_step    = 0;
      seq_count   = 0;
      live_lvls   = '0;
      pwm_ph      = '0;
      pin_bits    = '0;
      for (int i = 0; i < MAX_STEPS; i++) begin
         step_secs[i] = '0;
         step_lvls[i] = '0;
      end
      idle_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // one tick per second so the program walks quickly
      write_tps(TPS_W'(1));
      test_empty_table();
      test_clock_adjust();
      test_program_walk();
      test_delete_cases();
      test_random_mix();
      test_slow_divider();

      $display("covered %0d ms ticks, %0d pwm ticks, %0d toggles, %0d appends, %0d deletes,",
               beat_tally[ACT_MS_TICK], beat_tally[ACT_PWM_TICK], beat_tally[ACT_TOGGLE],
               beat_tally[ACT_APPEND], beat_tally[ACT_DELETE]);
      $display("%0d adjusts, %0d spare codes; %0d results checked, %0d step loads,",
               beat_tally[ACT_ADJUST], beat_tally[ACT_SPARE_A] + beat_tally[ACT_SPARE_B],
               results_checked, step_loads);
      $display("%0d table-full, %0d bad-index, %0d divider writes",
               full_errs, index_errs, tps_writes);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: files.f
rtl/tsps_pkg.sv
rtl/tsps_ctrl.sv
rtl/tsps_datapath.sv
rtl/timed_step_program_pwm_sequencer_core.sv
bench/testbench.sv
